[rtl/core/join_rate_token_bucket_top_macros.svh]
// Assertion macros for the join rate limiter checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef JOIN_RATE_TOKEN_BUCKET_TOP_MACROS_SVH
`define JOIN_RATE_TOKEN_BUCKET_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JRTB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jrtb same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define JRTB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jrtb next-cycle check failed");

`endif

[rtl/core/jrtb_pkg.sv]
package jrtb_pkg;

	// Default sizing.
	localparam int NUM_CHANNELS_DEF = 256;
	localparam int TIME_BITS_DEF    = 32;

	// Field widths.
	localparam int RATE_W  = 16;
	localparam int TOK_W   = 15;
	localparam int QUO_W   = TOK_W;
	localparam int DIV_CNT_W = $clog2(QUO_W);
	localparam int CFG_W   = 32;
	localparam int PADDR_W = 4;
	localparam int REG_IDX_W = 2;

	// Command codes.
	localparam logic [1:0] CMD_JOIN  = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_RATE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_WINDOW = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WARN_HOLDOFF   = 2'd2;

	// Register reset values.
	localparam logic signed [RATE_W-1:0] DEFAULT_RATE_RST   = 16'sd5;
	localparam logic signed [RATE_W-1:0] DEFAULT_WINDOW_RST = 16'sd5;
	localparam logic [RATE_W-1:0]        WARN_HOLDOFF_RST   = 16'd30;

	// Configuration values seen by the datapath.
	typedef struct packed {
		logic signed [RATE_W-1:0] default_rate;
		logic signed [RATE_W-1:0] default_window;
		logic [RATE_W-1:0]        warn_holdoff;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic load_in;
		logic rd;
		logic eval;
		logic calc;
		logic div_step;
		logic commit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic no_div;
	} sts_t;

endpackage

[rtl/core/jrtb_cfg.sv]
module jrtb_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [jrtb_pkg::PADDR_W-1:0]      paddr,
	input  logic [jrtb_pkg::CFG_W-1:0]        pwdata,
	output logic [jrtb_pkg::CFG_W-1:0]        prdata,
	output logic                              pready,
	output jrtb_pkg::cfg_t                    cfg
);

	logic signed [jrtb_pkg::RATE_W-1:0] default_rate_q;
	logic signed [jrtb_pkg::RATE_W-1:0] default_window_q;
	logic [jrtb_pkg::RATE_W-1:0]        warn_holdoff_q;
	logic [jrtb_pkg::REG_IDX_W-1:0]     reg_idx;
	logic                               wr_en;

	assign reg_idx = paddr[jrtb_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_rate_q   <= jrtb_pkg::DEFAULT_RATE_RST;
			default_window_q <= jrtb_pkg::DEFAULT_WINDOW_RST;
			warn_holdoff_q   <= jrtb_pkg::WARN_HOLDOFF_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				jrtb_pkg::REG_DEFAULT_RATE: begin
					default_rate_q <= pwdata[jrtb_pkg::RATE_W-1:0];
				end
				jrtb_pkg::REG_DEFAULT_WINDOW: begin
					default_window_q <= pwdata[jrtb_pkg::RATE_W-1:0];
				end
				jrtb_pkg::REG_WARN_HOLDOFF: begin
					warn_holdoff_q <= pwdata[jrtb_pkg::RATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read data; signed registers come back sign extended.
	always_comb begin
		unique case (reg_idx)
			jrtb_pkg::REG_DEFAULT_RATE:   prdata = jrtb_pkg::CFG_W'(default_rate_q);
			jrtb_pkg::REG_DEFAULT_WINDOW: prdata = jrtb_pkg::CFG_W'(default_window_q);
			jrtb_pkg::REG_WARN_HOLDOFF:   prdata = jrtb_pkg::CFG_W'(warn_holdoff_q);
			default:                      prdata = '0;
		endcase
	end

	assign cfg.default_rate   = default_rate_q;
	assign cfg.default_window = default_window_q;
	assign cfg.warn_holdoff   = warn_holdoff_q;

endmodule

[rtl/core/jrtb_ctrl.sv]
module jrtb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  jrtb_pkg::sts_t   sts,
	output jrtb_pkg::ctl_t   ctl
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_CALC,
		ST_DIV,
		ST_COMMIT
	} state_t;

	state_t                          state_q;
	logic [jrtb_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                            out_valid_q;
	logic                            slot_free;

	// The output register can take a new word when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Datapath commands follow the current state.
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_CLEAR:  ctl.clr_step = 1'b1;
			ST_IDLE:   ctl.load_in  = in_valid;
			ST_READ:   ctl.rd       = 1'b1;
			ST_EVAL:   ctl.eval     = 1'b1;
			ST_CALC:   ctl.calc     = 1'b1;
			ST_DIV:    ctl.div_step = 1'b1;
			ST_COMMIT: ctl.commit   = slot_free;
			default: begin
			end
		endcase
	end

	// State, divider step count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills at commit and empties when its word is taken.
			if (state_q == ST_COMMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (sts.no_div) begin
						state_q <= ST_COMMIT;
					end else begin
						state_q <= ST_DIV;
						cnt_q   <= jrtb_pkg::DIV_CNT_W'(jrtb_pkg::QUO_W - 1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_COMMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/jrtb_dp.sv]
module jrtb_dp #(
	parameter int NUM_CHANNELS = jrtb_pkg::NUM_CHANNELS_DEF,
	parameter int TIME_BITS    = jrtb_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  jrtb_pkg::ctl_t                      ctl,
	output jrtb_pkg::sts_t                      sts,
	input  jrtb_pkg::cfg_t                      cfg,
	input  logic [1:0]                          command,
	input  logic [7:0]                          channel,
	input  logic [31:0]                         now,
	input  logic signed [jrtb_pkg::RATE_W-1:0]  new_rate,
	input  logic signed [jrtb_pkg::RATE_W-1:0]  new_window,
	input  logic                                exempt,
	output logic                                warn,
	output logic                                token_taken,
	output logic [jrtb_pkg::TOK_W-1:0]          tokens_left,
	output logic                                checked
);

	localparam int CH_AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TOK_W  = jrtb_pkg::TOK_W;
	localparam int RATE_W = jrtb_pkg::RATE_W;
	localparam int PROD_W = 2 * TOK_W;

	typedef struct packed {
		logic                 ovr_valid;
		logic                 needs_fill;
		logic [TOK_W-1:0]     tokens;
		logic [TIME_BITS-1:0] last_join;
		logic [TIME_BITS-1:0] last_warn;
	} row_t;

	// Captured input word.
	logic [1:0]                cmd_q;
	logic [CH_AW-1:0]          idx_q;
	logic                      in_range_q;
	logic [TIME_BITS-1:0]      now_q;
	logic signed [RATE_W-1:0]  new_rate_q;
	logic signed [RATE_W-1:0]  new_window_q;
	logic                      exempt_q;
	logic [16:0]               ch_ext;
	logic [63:0]               now_ext;

	// Per-channel storage.
	row_t                      row_mem [NUM_CHANNELS];
	logic [2*RATE_W-1:0]       ovr_mem [NUM_CHANNELS];
	row_t                      row_rd_q;
	logic [2*RATE_W-1:0]       ovr_rd_q;
	logic [CH_AW-1:0]          clr_idx_q;

	// Evaluation registers.
	logic signed [RATE_W-1:0]  rate_sel;
	logic signed [RATE_W-1:0]  win_sel;
	logic                      counted;
	logic [TIME_BITS-1:0]      elapsed;
	logic [TOK_W-1:0]          rate_q;
	logic [TOK_W-1:0]          win_q;
	logic                      counted_q;
	logic [TIME_BITS-1:0]      elapsed_q;
	logic [TOK_W-1:0]          base_q;

	// Refill and warning check.
	logic                      full;
	logic                      full_q;
	logic                      warn_ok_q;
	logic [TIME_BITS-1:0]      warn_gap;
	logic [PROD_W-1:0]         prod;

	// Serial divider.
	logic [TOK_W-1:0]          rem_q;
	logic [TOK_W-1:0]          low_q;
	logic [TOK_W-1:0]          quot_q;
	logic [TOK_W:0]            rem_sh;
	logic                      rem_ge;

	// Commit.
	logic [TOK_W-1:0]          refill;
	logic [TOK_W:0]            tok_sum;
	logic [TOK_W-1:0]          tok_clamp;
	logic                      take;
	logic [TOK_W-1:0]          tok_new;
	logic                      warn_now;
	row_t                      row_wd;
	logic                      row_we;
	logic                      ovr_we;

	// Output word.
	logic                      warn_q;
	logic                      token_taken_q;
	logic [TOK_W-1:0]          tokens_left_q;
	logic                      checked_q;

	assign ch_ext  = 17'(channel);
	assign now_ext = 64'(now);

	// Capture the accepted input word.
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q        <= command;
			idx_q        <= ch_ext[CH_AW-1:0];
			in_range_q   <= (ch_ext < 17'(NUM_CHANNELS));
			now_q        <= now_ext[TIME_BITS-1:0];
			new_rate_q   <= new_rate;
			new_window_q <= new_window;
			exempt_q     <= exempt;
		end
	end

	// Clearing pass counter after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (ctl.clr_step) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_idx_q == CH_AW'(NUM_CHANNELS - 1));

	// Bucket memory: one write port shared by the clearing pass and commit.
	always_ff @(posedge clk) begin
		if (ctl.clr_step) begin
			row_mem[clr_idx_q] <= '{ovr_valid: 1'b0, needs_fill: 1'b1, tokens: '0,
				last_join: '0, last_warn: '0};
		end else if (ctl.commit && row_we) begin
			row_mem[idx_q] <= row_wd;
		end
		if (ctl.rd) begin
			row_rd_q <= row_mem[idx_q];
		end
	end

	// Override memory, written only by a set command.
	always_ff @(posedge clk) begin
		if (ctl.commit && ovr_we) begin
			ovr_mem[idx_q] <= {new_rate_q, new_window_q};
		end
		if (ctl.rd) begin
			ovr_rd_q <= ovr_mem[idx_q];
		end
	end

	// Pick override or default, decide whether the join is counted.
	always_comb begin
		rate_sel = row_rd_q.ovr_valid ? ovr_rd_q[2*RATE_W-1:RATE_W] : cfg.default_rate;
		win_sel  = row_rd_q.ovr_valid ? ovr_rd_q[RATE_W-1:0] : cfg.default_window;
		counted  = in_range_q && (cmd_q == jrtb_pkg::CMD_JOIN) && !exempt_q &&
			!rate_sel[RATE_W-1] && !win_sel[RATE_W-1] && (win_sel != '0);
		elapsed  = (now_q >= row_rd_q.last_join) ? (now_q - row_rd_q.last_join) : '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			rate_q    <= rate_sel[TOK_W-1:0];
			win_q     <= win_sel[TOK_W-1:0];
			counted_q <= counted;
			elapsed_q <= elapsed;
			base_q    <= row_rd_q.needs_fill ? rate_sel[TOK_W-1:0] : row_rd_q.tokens;
		end
	end

	// A full window refills the bucket; otherwise divide elapsed * rate by window.
	assign full       = (elapsed_q >= TIME_BITS'(win_q));
	assign sts.no_div = !counted_q || full;
	assign warn_gap   = now_q - row_rd_q.last_warn;
	assign prod       = PROD_W'(elapsed_q[TOK_W-1:0]) * PROD_W'(rate_q);

	// Restoring divider step: one quotient bit per cycle.
	assign rem_sh = {rem_q, low_q[TOK_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, win_q});

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			full_q    <= full;
			warn_ok_q <= (now_q >= row_rd_q.last_warn) &&
				(warn_gap >= TIME_BITS'(cfg.warn_holdoff));
			rem_q     <= prod[PROD_W-1:TOK_W];
			low_q     <= prod[TOK_W-1:0];
			quot_q    <= '0;
		end else if (ctl.div_step) begin
			rem_q  <= rem_ge ? TOK_W'(rem_sh - {1'b0, win_q}) : rem_sh[TOK_W-1:0];
			low_q  <= {low_q[TOK_W-2:0], 1'b0};
			quot_q <= {quot_q[TOK_W-2:0], rem_ge};
		end
	end

	// Refill, clamp to the rate and take a token if one is left.
	always_comb begin
		refill    = full_q ? rate_q : quot_q;
		tok_sum   = {1'b0, base_q} + {1'b0, refill};
		tok_clamp = (tok_sum > {1'b0, rate_q}) ? rate_q : tok_sum[TOK_W-1:0];
		take      = (tok_clamp != '0);
		tok_new   = take ? (tok_clamp - 1'b1) : tok_clamp;
		warn_now  = !take && warn_ok_q;
	end

	// Write-back row for the current command.
	always_comb begin
		row_wd = row_rd_q;
		row_we = 1'b0;
		ovr_we = 1'b0;
		unique case (cmd_q)
			jrtb_pkg::CMD_JOIN: begin
				if (counted_q) begin
					row_we            = 1'b1;
					row_wd.needs_fill = 1'b0;
					row_wd.tokens     = tok_new;
					row_wd.last_join  = now_q;
					if (warn_now) begin
						row_wd.last_warn = now_q;
					end
				end
			end
			jrtb_pkg::CMD_SET: begin
				row_we            = in_range_q;
				ovr_we            = in_range_q;
				row_wd.ovr_valid  = 1'b1;
				row_wd.needs_fill = 1'b1;
			end
			jrtb_pkg::CMD_CLEAR: begin
				row_we            = in_range_q;
				row_wd.ovr_valid  = 1'b0;
				row_wd.needs_fill = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			warn_q        <= counted_q && warn_now;
			token_taken_q <= counted_q && take;
			checked_q     <= counted_q;
			if (!in_range_q) begin
				tokens_left_q <= '0;
			end else if (counted_q) begin
				tokens_left_q <= tok_new;
			end else begin
				tokens_left_q <= row_rd_q.tokens;
			end
		end
	end

	assign warn        = warn_q;
	assign token_taken = token_taken_q;
	assign tokens_left = tokens_left_q;
	assign checked     = checked_q;

endmodule

[rtl/core/join_rate_token_bucket_top.sv]
// Per-channel join rate limiter with one token bucket per channel. After reset the
// block first sweeps its channel memory, one channel per cycle, and takes no input
// word during that pass. Configuration registers should be written only while no
// word is in flight. The block works on one input word at a time. A counted join
// whose elapsed time is shorter than its window passes through memory read,
// override selection and multiply, then a restoring divider for the refill quotient.
// Commands, exempt joins, disabled channels and joins whose elapsed time covers a
// full window skip the divider. A finished result word sits in an output register,
// so the next input word can be accepted while it waits to be taken; that word then
// holds before its own result until the register is free.
module join_rate_token_bucket_top #(
	parameter int NUM_CHANNELS = jrtb_pkg::NUM_CHANNELS_DEF,
	parameter int TIME_BITS    = jrtb_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [jrtb_pkg::PADDR_W-1:0]        paddr,
	input  logic [jrtb_pkg::CFG_W-1:0]          pwdata,
	output logic [jrtb_pkg::CFG_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          command,
	input  logic [7:0]                          channel,
	input  logic [31:0]                         now,
	input  logic signed [jrtb_pkg::RATE_W-1:0]  new_rate,
	input  logic signed [jrtb_pkg::RATE_W-1:0]  new_window,
	input  logic                                exempt,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                warn,
	output logic                                token_taken,
	output logic [jrtb_pkg::TOK_W-1:0]          tokens_left,
	output logic                                checked
);

	jrtb_pkg::cfg_t cfg;
	jrtb_pkg::ctl_t ctl;
	jrtb_pkg::sts_t sts;

	// Configuration registers.
	jrtb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencing of one word through the datapath.
	jrtb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Bucket storage, refill arithmetic and result register.
	jrtb_dp #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.TIME_BITS    (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg         (cfg),
		.command     (command),
		.channel     (channel),
		.now         (now),
		.new_rate    (new_rate),
		.new_window  (new_window),
		.exempt      (exempt),
		.warn        (warn),
		.token_taken (token_taken),
		.tokens_left (tokens_left),
		.checked     (checked)
	);

endmodule

[rtl/core/jrtb_chk.sv]
`include "join_rate_token_bucket_top_macros.svh"

module jrtb_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        warn,
	input logic                        token_taken,
	input logic [jrtb_pkg::TOK_W-1:0]  tokens_left,
	input logic                        checked
);

	// A join either takes a token or may warn, never both.
	`JRTB_ASSERT_NOW(a_warn_xor_take, out_valid, !(warn && token_taken))
	// Words that were not rate-checked carry no token or warning.
	`JRTB_ASSERT_NOW(a_unchecked_quiet, out_valid && !checked, !warn && !token_taken)
	// One word at a time: input is closed right after an acceptance.
	`JRTB_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	// A stalled result word stays put.
	`JRTB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tokens_left))

endmodule

bind join_rate_token_bucket_top jrtb_chk u_jrtb_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.warn        (warn),
	.token_taken (token_taken),
	.tokens_left (tokens_left),
	.checked     (checked)
);
